// ===== design/dsrm_pkg.sv =====
// Shared types and constants for the dot-star regex matcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package dsrm_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2,
    OP_END     = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] symbol;
    logic       is_star;
    logic       is_dot;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/dot_star_regex_matcher.sv =====
// Dot-star regex matcher, top level: input stage, command queue, match engine.
// Throughput: one item per cycle of any kind unless the output stalls; the text step is
// one position-set update. An end-of-text item goes through the input register, the
// queue and the engine into the output register before its result shows; an output
// stall holds it back.
// Reset: empty pattern, no overflow, only position zero active; token store is not cleared.
`default_nettype none

module dot_star_regex_matcher #(
  parameter int PatternMax = dsrm_pkg::PATTERN_MAX_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  wire logic [1:0] s_axis_tuser,   // [1:0] kind
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [0] matched, [1] overflowed, [7:2] zero
);
  import dsrm_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready, back_valid, back_ready;
  logic matched, overflowed;

  dsrm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .symbol_i    (s_axis_tdata),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  dsrm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  dsrm_back #(
    .PatternMax (PatternMax)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (back_valid),
    .cmd_ready_o  (back_ready),
    .cmd_i        (back_cmd),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .matched_o    (matched),
    .overflowed_o (overflowed)
  );

  assign m_axis_tdata = {6'b0, overflowed, matched};

endmodule

`default_nettype wire

// ===== design/dsrm_front.sv =====
// Input stage: accepts stream items, decodes kind and classifies the symbol.
// Depends on dsrm_pkg.
`default_nettype none

module dsrm_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire logic [1:0]    kind_i,
  input  wire logic [7:0]    symbol_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output dsrm_pkg::cmd_t     cmd_o
);
  import dsrm_pkg::*;

  logic valid_q;
  cmd_t cmd_q;
  cmd_t cmd_d;

  always_comb begin
    cmd_d.op      = op_e'(kind_i);
    cmd_d.symbol  = symbol_i;
    cmd_d.is_star = (symbol_i == STAR_CHAR);
    cmd_d.is_dot  = (symbol_i == DOT_CHAR);
  end

  assign s_ready_o   = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/dsrm_queue.sv =====
// Short command queue between the input stage and the match engine.
// Depends on dsrm_pkg.
`default_nettype none

module dsrm_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire dsrm_pkg::cmd_t push_cmd_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output dsrm_pkg::cmd_t     pop_cmd_o
);
  import dsrm_pkg::*;

  localparam int Depth = QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/dsrm_back.sv =====
// Match engine: token store, active position set with star closure, verdict register.
// Depends on dsrm_pkg.
`default_nettype none

module dsrm_back #(
  parameter int PatternMax = dsrm_pkg::PATTERN_MAX_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire dsrm_pkg::cmd_t cmd_i,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output logic               matched_o,
  output logic               overflowed_o
);
  import dsrm_pkg::*;

  localparam int N    = PatternMax;
  localparam int CntW = $clog2(N + 1);
  localparam int IdxW = (N > 1) ? $clog2(N) : 1;

  logic [CntW-1:0] cnt_q;
  logic            ovf_q;
  logic [N:0]      act_q;
  logic [7:0]      tok_byte_q [N];
  logic [N-1:0]    tok_star_q, tok_dot_q;
  logic            out_valid_q, out_matched_q, out_ovf_q;

  logic [N-1:0]    below, hit;
  logic [N:0]      prop, seed, sum, carry, cur, nxt;
  logic [CntW-1:0] cnt_m1;
  logic [IdxW-1:0] last_idx, wr_idx;
  logic            fire, star_ext, full;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      below[i] = (CntW'(i) < cnt_q);
    end
  end

  // star closure as a carry chain: starred tokens propagate, active starred ones generate
  assign prop  = {1'b0, tok_star_q & below};
  assign seed  = act_q & prop;
  assign sum   = prop + seed;
  assign carry = sum ^ prop ^ seed;
  assign cur   = act_q | carry;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit[i] = cur[i] && below[i] && (tok_dot_q[i] || (tok_byte_q[i] == cmd_i.symbol));
    end
  end

  assign nxt = {1'b0, hit & tok_star_q} | {hit & ~tok_star_q, 1'b0};

  assign cnt_m1   = cnt_q - CntW'(1);
  assign last_idx = cnt_m1[IdxW-1:0];
  assign wr_idx   = cnt_q[IdxW-1:0];
  assign full     = (cnt_q == CntW'(N));
  assign star_ext = cmd_i.is_star && (cnt_q != '0) && !tok_star_q[last_idx];

  assign cmd_ready_o = (cmd_i.op != OP_END) || !out_valid_q || m_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;

  assign m_valid_o    = out_valid_q;
  assign matched_o    = out_matched_q;
  assign overflowed_o = out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      act_q       <= (N + 1)'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (fire && cmd_i.op == OP_END) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        case (cmd_i.op)
          OP_CLEAR: begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
            act_q <= (N + 1)'(1);
          end
          OP_PATTERN: begin
            if (!ovf_q && !star_ext) begin
              if (full) begin
                ovf_q <= 1'b1;
              end else begin
                cnt_q <= cnt_q + CntW'(1);
              end
            end
          end
          OP_TEXT: begin
            act_q <= nxt;
          end
          OP_END: begin
            act_q <= (N + 1)'(1);
          end
          default: begin
            act_q <= act_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && cmd_i.op == OP_PATTERN && !ovf_q) begin
      if (star_ext) begin
        tok_star_q[last_idx] <= 1'b1;
      end else if (!full) begin
        tok_byte_q[wr_idx] <= cmd_i.symbol;
        tok_star_q[wr_idx] <= 1'b0;
        tok_dot_q[wr_idx]  <= cmd_i.is_dot;
      end
    end
    if (fire && cmd_i.op == OP_END) begin
      out_matched_q <= cur[cnt_q] && !ovf_q;
      out_ovf_q     <= ovf_q;
    end
  end

endmodule

`default_nettype wire

// ===== verif/dot_star_regex_matcher_tb.sv =====
// Self-checking testbench for dot_star_regex_matcher: directed and random match sessions,
// checked against an in-bench position-set predictor. Needs dsrm_pkg and the matcher RTL.
`timescale 1ns / 100ps

module dot_star_regex_matcher_tb;
  import dsrm_pkg::*;

  localparam int PMAX           = PATTERN_MAX_DEF;
  localparam int END_LATENCY    = 2;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1350;

  typedef struct packed {
    bit matched;
    bit overflowed;
  } verdict_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // [7:0] symbol
  logic [1:0] s_axis_tuser  = '0;   // [1:0] kind
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [0] matched, [1] overflowed, [7:2] zero

  dot_star_regex_matcher #(.PatternMax(PMAX)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // matcher state as predicted
  bit [7:0]    tok_byte [PMAX];
  bit          tok_star [PMAX];
  int unsigned tok_count;
  bit [PMAX:0] live_pos;
  bit          pat_ovf;

  verdict_t    verdict_q[$];
  int unsigned items_sent;
  int unsigned verdicts_checked;
  int unsigned matches_seen;
  int unsigned ovf_seen;
  int unsigned fails;
  bit          no_idle;
  int unsigned hold_asked;
  int unsigned hold_done;

  initial begin
    tok_count = 0;
    live_pos  = (PMAX + 1)'(1);
    pat_ovf   = 1'b0;
  end

  function automatic bit [PMAX:0] star_closure(bit [PMAX:0] s);
    for (int i = 0; i < tok_count; i++) begin
      if (s[i] && tok_star[i]) s[i+1] = 1'b1;
    end
    return s;
  endfunction

  function automatic void matcher_model_step(op_e kind, logic [7:0] sym);
    bit [PMAX:0] cur;
    bit [PMAX:0] nxt;
    verdict_t    v;
    case (kind)
      OP_CLEAR: begin
        tok_count = 0;
        pat_ovf   = 1'b0;
        live_pos  = (PMAX + 1)'(1);
      end
      OP_PATTERN: begin
        if (!pat_ovf) begin
          if (sym == STAR_CHAR && tok_count > 0 && !tok_star[tok_count-1]) begin
            tok_star[tok_count-1] = 1'b1;
          end else if (tok_count >= PMAX) begin
            pat_ovf = 1'b1;
          end else begin
            tok_byte[tok_count] = sym;
            tok_star[tok_count] = 1'b0;
            tok_count++;
          end
        end
      end
      OP_TEXT: begin
        cur = star_closure(live_pos);
        nxt = '0;
        for (int i = 0; i < tok_count; i++) begin
          if (cur[i] && (tok_byte[i] == DOT_CHAR || tok_byte[i] == sym)) begin
            if (tok_star[i]) nxt[i] = 1'b1;
            else nxt[i+1] = 1'b1;
          end
        end
        live_pos = nxt;
      end
      OP_END: begin
        cur          = star_closure(live_pos);
        v.matched    = cur[tok_count] && !pat_ovf;
        v.overflowed = pat_ovf;
        verdict_q.push_back(v);
        live_pos = (PMAX + 1)'(1);
      end
    endcase
  endfunction

  task automatic send_item(op_e kind, logic [7:0] sym);
    while (!no_idle && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= sym;
    do @(posedge clk_i); while (!s_axis_tready);
    matcher_model_step(kind, sym);
    items_sent++;
  endtask

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    fails++;
  endtask

  function automatic logic [7:0] pattern_sym();
    case ($urandom_range(0, 9))
      0, 1, 2: return "a";
      3, 4:    return "b";
      5:       return DOT_CHAR;
      6, 7:    return STAR_CHAR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] text_sym();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return "a";
      4, 5:       return "b";
      6:          return STAR_CHAR;
      7:          return DOT_CHAR;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  always @(posedge clk_i) begin : verdict_checker
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict with none pending", 0, 32'(m_axis_tdata));
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[0] !== want.matched)
          report_mismatch("matched", 32'(want.matched), 32'(m_axis_tdata[0]));
        if (m_axis_tdata[1] !== want.overflowed)
          report_mismatch("overflowed", 32'(want.overflowed), 32'(m_axis_tdata[1]));
        if (m_axis_tdata[7:2] !== 6'd0)
          report_mismatch("pad bits", 0, 32'(m_axis_tdata[7:2]));
        verdicts_checked++;
        if (want.matched) matches_seen++;
        if (want.overflowed) ovf_seen++;
      end
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        hold_done++;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no item moved for %0d cycles", quiet);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic test_directed_cases();
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_END, 8'h00);          // empty pattern, empty text
    send_item(OP_PATTERN, "a");
    send_item(OP_PATTERN, STAR_CHAR);  // stars 'a'
    send_item(OP_PATTERN, STAR_CHAR);  // literal star
    send_item(OP_PATTERN, DOT_CHAR);
    send_item(OP_TEXT, "a");
    send_item(OP_TEXT, "a");
    send_item(OP_TEXT, STAR_CHAR);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_END, 8'hFF);
    send_item(OP_END, 8'h55);          // empty text, non-empty pattern
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_PATTERN, 8'h00);
    send_item(OP_PATTERN, 8'hFF);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_END, 8'hAA);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_PATTERN, STAR_CHAR);  // arrives mid-text
    send_item(OP_END, 8'h00);
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_PATTERN, STAR_CHAR);  // leading star is literal
    send_item(OP_TEXT, STAR_CHAR);
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_pattern_overflow();
    send_item(OP_CLEAR, 8'h00);
    repeat (PMAX - 1) send_item(OP_PATTERN, DOT_CHAR);
    send_item(OP_PATTERN, "q");
    send_item(OP_PATTERN, STAR_CHAR);  // star on a full pattern
    repeat (PMAX - 1) send_item(OP_TEXT, "z");
    send_item(OP_END, 8'h00);
    send_item(OP_PATTERN, "r");        // no room left
    send_item(OP_PATTERN, STAR_CHAR);
    send_item(OP_TEXT, "a");
    send_item(OP_END, 8'h00);
    send_item(OP_END, 8'h00);
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_random_sessions(int unsigned target);
    logic [7:0]  pat[$];
    logic [7:0]  txt[$];
    logic [7:0]  b;
    int unsigned plen;
    int unsigned reps;
    int unsigned i;
    bit          starred;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 10) begin
        send_item(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 9) != 0) send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
        plen = ($urandom_range(0, 14) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 7);
        pat.delete();
        repeat (plen) begin
          b = pattern_sym();
          pat.push_back(b);
          send_item(OP_PATTERN, b);
        end
        repeat ($urandom_range(1, 4)) begin
          txt.delete();
          if ($urandom_range(0, 2) != 0) begin
            // walk the tokens to build a likely match
            i = 0;
            while (i < pat.size()) begin
              starred = (i + 1 < pat.size()) && (pat[i+1] == STAR_CHAR);
              reps = starred ? $urandom_range(0, 2) : 1;
              repeat (reps) txt.push_back((pat[i] == DOT_CHAR) ? text_sym() : pat[i]);
              i += starred ? 2 : 1;
            end
            if (txt.size() > 0 && $urandom_range(0, 3) == 0)
              txt[$urandom_range(0, txt.size() - 1)] = text_sym();
          end else begin
            repeat ($urandom_range(0, 8)) txt.push_back(text_sym());
          end
          foreach (txt[k]) begin
            if ($urandom_range(0, 39) == 0) send_item(OP_PATTERN, pattern_sym());
            send_item(OP_TEXT, txt[k]);
          end
          send_item(OP_END, 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  task automatic test_unbroken_burst();
    no_idle = 1'b1;
    test_random_sessions(items_sent + 250);
    no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    hold_asked++;
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_PATTERN, "a");
    send_item(OP_PATTERN, STAR_CHAR);
    repeat (8) begin
      send_item(OP_TEXT, "a");
      send_item(OP_END, 8'h00);
    end
    repeat (4) send_item(OP_END, 8'h00);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_pattern_overflow();
    test_output_backpressure();
    test_unbroken_burst();
    test_random_sessions(ITEM_TARGET);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (END_LATENCY + 8) @(posedge clk_i);
    $display("Sent %0d items across clear, pattern, text and end-of-text kinds.", items_sent);
    $display("Checked %0d verdicts: %0d matches, %0d with pattern overflow.",
             verdicts_checked, matches_seen, ovf_seen);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
